@@ src/sum_pkg.sv @@
// ----------------------------------------------------------------------------
// sum_pkg
// Shared types and constants of the sorted union merge block.
// ----------------------------------------------------------------------------
package sum_pkg;

   localparam int FIRST_DEPTH  = 32;
   localparam int SECOND_DEPTH = 32;
   localparam int VALUE_W      = 32;

   // Address and count widths for each list buffer.
   localparam int FIRST_AW  = (FIRST_DEPTH > 1) ? $clog2(FIRST_DEPTH) : 1;
   localparam int SECOND_AW = (SECOND_DEPTH > 1) ? $clog2(SECOND_DEPTH) : 1;
   localparam int FIRST_CW  = $clog2(FIRST_DEPTH + 1);
   localparam int SECOND_CW = $clog2(SECOND_DEPTH + 1);

   typedef logic [1:0] action_type;

   localparam action_type ACT_LOAD_FIRST  = 2'd0;
   localparam action_type ACT_LOAD_SECOND = 2'd1;
   localparam action_type ACT_RUN         = 2'd2;

   typedef struct packed {
      action_type                 action;
      logic signed [VALUE_W-1:0]  value;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0]  value_res;
      logic                       last;
      logic                       empty_res;
      logic                       overflow;
   } rsp_type;

   // One merge candidate from the sequencer to the output stage.
   typedef struct packed {
      logic                       valid;
      logic                       finish;
      logic                       overflow;
      logic signed [VALUE_W-1:0]  value;
   } cand_type;

endpackage

@@ src/sorted_union_merge.sv @@
// ----------------------------------------------------------------------------
// sorted_union_merge
// Loads two ascending lists into buffers and merges them into their union,
// one distinct value per result transaction, or one flagged transaction if both are empty.
// ----------------------------------------------------------------------------
//  channel  direction  handshake            payload
//  req      in         req_valid/req_stall  req_payload (action, value)
//  rsp      out        rsp_valid/rsp_stall  rsp_payload (value_res, last, empty_res, overflow)
//
// A load writes one buffer entry, or sets the overflow flag if that buffer is
// full; loads may follow each other in every cycle. A run holds req_stall
// high while the two buffer read pointers step through the stored elements,
// through one closing step and through any stalls of the result side. The
// last result transaction is presented in the cycle after the closing step.
// Reset is synchronous and clears the counts and the overflow flag; the
// buffers need no clearing pass, since only filled entries are ever used.
// ----------------------------------------------------------------------------
module sorted_union_merge (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  sum_pkg::req_type   req_payload,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output sum_pkg::rsp_type   rsp_payload
);

   logic                             wr_en_a, wr_en_b;
   logic [sum_pkg::FIRST_AW-1:0]     wr_addr_a, rd_addr_a;
   logic [sum_pkg::SECOND_AW-1:0]    wr_addr_b, rd_addr_b;
   logic [sum_pkg::VALUE_W-1:0]      rd_data_a, rd_data_b;
   sum_pkg::cand_type                cand;
   logic                             cand_ready;

   sum_ram #(
      .WIDTH (sum_pkg::VALUE_W),
      .DEPTH (sum_pkg::FIRST_DEPTH)
   ) u_first_ram (
      .clock   (clock),
      .wr_en   (wr_en_a),
      .wr_addr (wr_addr_a),
      .wr_data (req_payload.value),
      .rd_addr (rd_addr_a),
      .rd_data (rd_data_a)
   );

   sum_ram #(
      .WIDTH (sum_pkg::VALUE_W),
      .DEPTH (sum_pkg::SECOND_DEPTH)
   ) u_second_ram (
      .clock   (clock),
      .wr_en   (wr_en_b),
      .wr_addr (wr_addr_b),
      .wr_data (req_payload.value),
      .rd_addr (rd_addr_b),
      .rd_data (rd_data_b)
   );

   sum_merge u_merge (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .wr_en_a     (wr_en_a),
      .wr_addr_a   (wr_addr_a),
      .wr_en_b     (wr_en_b),
      .wr_addr_b   (wr_addr_b),
      .rd_addr_a   (rd_addr_a),
      .rd_addr_b   (rd_addr_b),
      .rd_data_a   (rd_data_a),
      .rd_data_b   (rd_data_b),
      .cand        (cand),
      .cand_ready  (cand_ready)
   );

   sum_emit u_emit (
      .clock       (clock),
      .reset       (reset),
      .cand        (cand),
      .cand_ready  (cand_ready),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

@@ src/sum_ram.sv @@
// ----------------------------------------------------------------------------
// sum_ram
// Generic single write port, single read port RAM with a registered read.
// ----------------------------------------------------------------------------
module sum_ram #(
   parameter int  WIDTH = 32,
   parameter int  DEPTH = 32,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/sum_merge.sv @@
// ----------------------------------------------------------------------------
// sum_merge
// Load and merge sequencer: fills both list buffers and walks them with two
// pointers during a run, offering one candidate value per cycle.
// ----------------------------------------------------------------------------
module sum_merge (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  sum_pkg::req_type                 req_payload,
   output logic                             wr_en_a,
   output logic [sum_pkg::FIRST_AW-1:0]     wr_addr_a,
   output logic                             wr_en_b,
   output logic [sum_pkg::SECOND_AW-1:0]    wr_addr_b,
   output logic [sum_pkg::FIRST_AW-1:0]     rd_addr_a,
   output logic [sum_pkg::SECOND_AW-1:0]    rd_addr_b,
   input  logic [sum_pkg::VALUE_W-1:0]      rd_data_a,
   input  logic [sum_pkg::VALUE_W-1:0]      rd_data_b,
   output sum_pkg::cand_type                cand,
   input  logic                             cand_ready
);

   typedef enum logic {
      ST_IDLE,
      ST_MERGE
   } state_type;

   state_type                       state_ff, state_in;
   logic [sum_pkg::FIRST_CW-1:0]    cnt_a_ff, cnt_a_in, ptr_a_ff, ptr_a_in;
   logic [sum_pkg::SECOND_CW-1:0]   cnt_b_ff, cnt_b_in, ptr_b_ff, ptr_b_in;
   logic                            dropped_ff, dropped_in;
   logic                            accept;
   logic                            has_a, has_b, take_a, take_b;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;

   assign has_a  = (ptr_a_ff < cnt_a_ff);
   assign has_b  = (ptr_b_ff < cnt_b_ff);
   assign take_a = (state_ff == ST_MERGE) && has_a &&
                   (!has_b || ($signed(rd_data_a) <= $signed(rd_data_b)));
   assign take_b = (state_ff == ST_MERGE) && has_b && !take_a;

   always_comb begin
      cand.valid    = take_a || take_b;
      cand.finish   = (state_ff == ST_MERGE) && !has_a && !has_b;
      cand.overflow = dropped_ff;
      cand.value    = take_a ? $signed(rd_data_a) : $signed(rd_data_b);
   end

   // Loads write at the current fill count.
   assign wr_en_a   = accept && (req_payload.action == sum_pkg::ACT_LOAD_FIRST) &&
                      (cnt_a_ff < sum_pkg::FIRST_CW'(sum_pkg::FIRST_DEPTH));
   assign wr_en_b   = accept && (req_payload.action == sum_pkg::ACT_LOAD_SECOND) &&
                      (cnt_b_ff < sum_pkg::SECOND_CW'(sum_pkg::SECOND_DEPTH));
   assign wr_addr_a = cnt_a_ff[sum_pkg::FIRST_AW-1:0];
   assign wr_addr_b = cnt_b_ff[sum_pkg::SECOND_AW-1:0];

   always_comb begin
      state_in   = state_ff;
      cnt_a_in   = cnt_a_ff;
      cnt_b_in   = cnt_b_ff;
      ptr_a_in   = ptr_a_ff;
      ptr_b_in   = ptr_b_ff;
      dropped_in = dropped_ff;
      case (state_ff)
         ST_IDLE: begin
            ptr_a_in = '0;
            ptr_b_in = '0;
            if (accept) begin
               case (req_payload.action)
                  sum_pkg::ACT_LOAD_FIRST: begin
                     if (wr_en_a) begin
                        cnt_a_in = cnt_a_ff + 1'b1;
                     end else begin
                        dropped_in = 1'b1;
                     end
                  end
                  sum_pkg::ACT_LOAD_SECOND: begin
                     if (wr_en_b) begin
                        cnt_b_in = cnt_b_ff + 1'b1;
                     end else begin
                        dropped_in = 1'b1;
                     end
                  end
                  sum_pkg::ACT_RUN: begin
                     state_in = ST_MERGE;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_MERGE: begin
            if (cand_ready) begin
               if (take_a) begin
                  ptr_a_in = ptr_a_ff + 1'b1;
               end
               if (take_b) begin
                  ptr_b_in = ptr_b_ff + 1'b1;
               end
               if (cand.finish) begin
                  state_in   = ST_IDLE;
                  cnt_a_in   = '0;
                  cnt_b_in   = '0;
                  ptr_a_in   = '0;
                  ptr_b_in   = '0;
                  dropped_in = 1'b0;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // The read address follows the next pointer, so the registered read data
   // always matches the pointer in the following cycle.
   assign rd_addr_a = ptr_a_in[sum_pkg::FIRST_AW-1:0];
   assign rd_addr_b = ptr_b_in[sum_pkg::SECOND_AW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         cnt_a_ff   <= '0;
         cnt_b_ff   <= '0;
         ptr_a_ff   <= '0;
         ptr_b_ff   <= '0;
         dropped_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         cnt_a_ff   <= cnt_a_in;
         cnt_b_ff   <= cnt_b_in;
         ptr_a_ff   <= ptr_a_in;
         ptr_b_ff   <= ptr_b_in;
         dropped_ff <= dropped_in;
      end
   end

endmodule

@@ src/sum_emit.sv @@
// ----------------------------------------------------------------------------
// sum_emit
// Output stage: drops repeated candidates, holds the newest distinct value
// until the next one shows whether it is the last, and drives the result
// register.
// ----------------------------------------------------------------------------
module sum_emit (
   input  logic                 clock,
   input  logic                 reset,
   input  sum_pkg::cand_type    cand,
   output logic                 cand_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output sum_pkg::rsp_type     rsp_payload
);

   logic                              pend_valid_ff, pend_valid_in;
   logic signed [sum_pkg::VALUE_W-1:0] pend_value_ff, pend_value_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   sum_pkg::rsp_type                  rsp_ff, rsp_in;
   logic                              out_free, is_new, need_out;

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign is_new     = cand.valid && (!pend_valid_ff || (cand.value != pend_value_ff));
   assign need_out   = (is_new && pend_valid_ff) || cand.finish;
   assign cand_ready = !need_out || out_free;

   always_comb begin
      pend_valid_in = pend_valid_ff;
      pend_value_in = pend_value_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_in        = rsp_ff;
      if (out_free) begin
         rsp_valid_in = need_out;
      end
      if (cand_ready) begin
         if (need_out) begin
            rsp_in.value_res = pend_value_ff;
            rsp_in.last      = cand.finish;
            rsp_in.empty_res = 1'b0;
            rsp_in.overflow  = cand.overflow;
            if (cand.finish && !pend_valid_ff) begin
               // Both lists were empty: one flagged transaction.
               rsp_in.value_res = '0;
               rsp_in.empty_res = 1'b1;
            end
         end
         if (is_new) begin
            pend_valid_in = 1'b1;
            pend_value_in = cand.value;
         end
         if (cand.finish) begin
            pend_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      pend_value_ff <= pend_value_in;
      rsp_ff        <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule
